[rtl/core/ism_pkg.sv]
// ism_pkg: shared types and the ordering function of the interval sort and merge block.
// Used by ism_cell, ism_merge and interval_sort_merge_top; depends on nothing.
package ism_pkg;

   typedef struct packed {
      logic signed [31:0] lo;
      logic signed [31:0] hi;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic load;
      logic walk;
      logic flush;
   } merge_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_FLUSH
   } state_type;

   // lexicographic (start, end) strict ordering
   function automatic logic goes_before(entry_type a, entry_type b);
      logic res;
      if (a.lo != b.lo) begin
         res = a.lo < b.lo;
      end else begin
         res = a.hi < b.hi;
      end
      return res;
   endfunction

endpackage

[rtl/core/ism_cell.sv]
// ism_cell: one slot of the insertion-sort chain; holds one interval.
// Depends on ism_pkg (entry_type, cell_ctrl_type, goes_before).
module ism_cell (
   input  logic                  clock,
   input  ism_pkg::entry_type    new_item,
   input  ism_pkg::entry_type    prev_item,
   input  logic                  prev_ahead,
   input  logic                  prev_occ,
   input  ism_pkg::entry_type    next_item,
   input  logic                  occ,
   input  ism_pkg::cell_ctrl_type ctrl,
   output ism_pkg::entry_type    item,
   output logic                  ahead
);

   ism_pkg::entry_type item_ff;
   ism_pkg::entry_type item_in;

   assign ahead = ism_pkg::goes_before(new_item, item_ff);
   assign item  = item_ff;

   always_comb begin
      item_in = item_ff;
      if (ctrl.shift) begin
         item_in = next_item;
      end else if (ctrl.insert) begin
         // shift up behind a larger neighbour, or take the new word at its place
         if (prev_occ && prev_ahead) begin
            item_in = prev_item;
         end else if (!occ || ahead) begin
            item_in = new_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

[rtl/core/ism_merge.sv]
// ism_merge: current merged interval and the registered result word.
// Depends on ism_pkg (entry_type, merge_ctrl_type).
module ism_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  ism_pkg::merge_ctrl_type ctrl,
   input  ism_pkg::entry_type     head,
   input  logic                   dropped,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_merged_start,
   output logic signed [31:0]     rsp_merged_end,
   output logic                   rsp_merged_last,
   output logic                   rsp_overflow
);

   ism_pkg::entry_type cur_ff, cur_in;
   logic               valid_ff, valid_in;
   ism_pkg::entry_type out_ff, out_in;
   logic               last_ff, last_in;
   logic               ovf_ff, ovf_in;
   logic               overlap;

   assign overlap = cur_ff.hi >= head.lo;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = 1'b0;
      out_in   = out_ff;
      last_in  = last_ff;
      ovf_in   = ovf_ff;
      if (ctrl.load) begin
         cur_in = head;
      end else if (ctrl.walk) begin
         if (overlap) begin
            if (head.hi > cur_ff.hi) begin
               cur_in.hi = head.hi;
            end
         end else begin
            valid_in = 1'b1;
            out_in   = cur_ff;
            last_in  = 1'b0;
            ovf_in   = dropped;
            cur_in   = head;
         end
      end else if (ctrl.flush) begin
         valid_in = 1'b1;
         out_in   = cur_ff;
         last_in  = 1'b1;
         ovf_in   = dropped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cur_ff  <= cur_in;
      out_ff  <= out_in;
      last_ff <= last_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_merged_start = out_ff.lo;
   assign rsp_merged_end   = out_ff.hi;
   assign rsp_merged_last  = last_ff;
   assign rsp_overflow     = ovf_ff;

endmodule

[rtl/core/interval_sort_merge_top.sv]
// interval_sort_merge_top: chain of sorting cells, sequencer and merge unit.
// Depends on ism_pkg, ism_cell and ism_merge.
//
//   channel   ports                                   handshake
//   request   req_interval_start/end, req_set_last    start & !busy
//   response  rsp_merged_start/end/last, rsp_overflow rsp_valid strobe, one cycle
//
// Loading takes a word on each accepted start: every cell compares in parallel and the
// chain shifts in one step. After a word with req_set_last the chain shifts its head
// into the merge unit one entry per cycle. Results leave as they are found; the
// receiver cannot stall.
// Synchronous reset clears the sequencer, the fill count and the drop flag.
module interval_sort_merge_top #(
   parameter int MAX_INTERVALS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_interval_start,
   input  logic signed [31:0] req_interval_end,
   input  logic               req_set_last,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_merged_start,
   output logic signed [31:0] rsp_merged_end,
   output logic               rsp_merged_last,
   output logic               rsp_overflow
);

   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

   ism_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        remain_ff, remain_in;
   logic                    dropped_ff, dropped_in;
   logic                    accept, full;
   ism_pkg::cell_ctrl_type  cell_ctrl;
   ism_pkg::merge_ctrl_type merge_ctrl;
   ism_pkg::entry_type      new_item;
   ism_pkg::entry_type      items  [MAX_INTERVALS];
   logic                    aheads [MAX_INTERVALS];
   logic                    occs   [MAX_INTERVALS];

   assign busy   = state_ff != ism_pkg::ST_IDLE;
   assign accept = start && !busy;
   assign full   = count_ff >= CNT_W'(MAX_INTERVALS);

   assign new_item.lo = req_interval_start;
   assign new_item.hi = req_interval_end;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ism_pkg::ST_IDLE: begin
            if (accept && req_set_last) state_in = ism_pkg::ST_LOAD;
         end
         ism_pkg::ST_LOAD: begin
            state_in = (count_ff > CNT_W'(1)) ? ism_pkg::ST_WALK : ism_pkg::ST_FLUSH;
         end
         ism_pkg::ST_WALK: begin
            if (remain_ff == CNT_W'(1)) state_in = ism_pkg::ST_FLUSH;
         end
         ism_pkg::ST_FLUSH: begin
            state_in = ism_pkg::ST_IDLE;
         end
         default: begin
            state_in = ism_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      cell_ctrl.insert = accept && !full;
      cell_ctrl.shift  = 1'b0;
      merge_ctrl       = '0;
      count_in         = count_ff;
      remain_in        = remain_ff;
      dropped_in       = dropped_ff;
      if (accept) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      case (state_ff)
         ism_pkg::ST_LOAD: begin
            cell_ctrl.shift = 1'b1;
            merge_ctrl.load = 1'b1;
            remain_in       = count_ff - CNT_W'(1);
         end
         ism_pkg::ST_WALK: begin
            cell_ctrl.shift = 1'b1;
            merge_ctrl.walk = 1'b1;
            remain_in       = remain_ff - CNT_W'(1);
         end
         ism_pkg::ST_FLUSH: begin
            merge_ctrl.flush = 1'b1;
            count_in         = '0;
            dropped_in       = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ism_pkg::ST_IDLE;
         count_ff   <= '0;
         remain_ff  <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         remain_ff  <= remain_in;
         dropped_ff <= dropped_in;
      end
   end

   for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
      ism_pkg::entry_type prev_item, next_item;
      logic               prev_ahead, prev_occ;

      assign occs[i] = count_ff > CNT_W'(i);

      if (i == 0) begin : g_first
         assign prev_item  = new_item;
         assign prev_ahead = 1'b0;
         assign prev_occ   = 1'b0;
      end else begin : g_rest
         assign prev_item  = items[i-1];
         assign prev_ahead = aheads[i-1];
         assign prev_occ   = occs[i-1];
      end

      if (i == MAX_INTERVALS - 1) begin : g_tail
         assign next_item = items[i];
      end else begin : g_body
         assign next_item = items[i+1];
      end

      ism_cell u_cell (
         .clock       (clock),
         .new_item    (new_item),
         .prev_item   (prev_item),
         .prev_ahead  (prev_ahead),
         .prev_occ    (prev_occ),
         .next_item   (next_item),
         .occ         (occs[i]),
         .ctrl        (cell_ctrl),
         .item        (items[i]),
         .ahead       (aheads[i])
      );
   end

   ism_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (merge_ctrl),
      .head             (items[0]),
      .dropped          (dropped_ff),
      .rsp_valid        (rsp_valid),
      .rsp_merged_start (rsp_merged_start),
      .rsp_merged_end   (rsp_merged_end),
      .rsp_merged_last  (rsp_merged_last),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
